[rtl/core/preemptive_priority_scheduler_unit_defines.svh]
// assertion macros shared by the scheduler checker
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off while in reset
`define PPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, sampled on the rising clock, off while in reset
`define PPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

[rtl/core/pps_pkg.sv]
// shared types, constants and helpers of the priority scheduler
package pps_pkg;

    localparam int          MAX_PROCS_DEF  = 16;
    localparam logic [4:0]  PROC_COUNT_RST = 5'd16;
    localparam logic [4:0]  FIN_MAX        = 5'd31;
    localparam logic [8:0]  NO_PRIO        = 9'd256;
    localparam logic [23:0] TICK_MAX       = 24'hFFFFFF;
    localparam logic [31:0] SUM_MAX        = 32'hFFFF_FFFF;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_WAIT,
        ST_OUT
    } t_state;

    // token that travels down the cell row during a scan
    typedef struct packed {
        logic        cand_valid;
        logic [8:0]  best_prio;
        logic [4:0]  scan_left;
        logic [15:0] cand_arrival;
        logic [15:0] cand_burst;
        logic        cand_last;
        logic [15:0] cur_arrival;
        logic [15:0] cur_burst;
        logic        cur_last;
    } t_tok;

    // slot write broadcast to every cell
    typedef struct packed {
        logic        en;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } t_load;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SUM_MAX : s[31:0];
    endfunction

endpackage

[rtl/core/pps_cell.sv]
// one process slot of the scheduler row with its scan compare stage
module pps_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pps_pkg::t_tok     i_tok,
    input  logic [IDX_W-1:0]  i_cand_idx,
    output pps_pkg::t_tok     o_tok,
    output logic [IDX_W-1:0]  o_cand_idx,
    input  logic [23:0]       i_tick,
    input  logic [IDX_W-1:0]  i_cur_idx,
    input  pps_pkg::t_load    i_load,
    input  logic [IDX_W-1:0]  i_load_idx,
    input  logic              i_dec_en,
    input  logic [IDX_W-1:0]  i_dec_idx
);
    import pps_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [15:0] r_arrival;
    logic [15:0] r_burst;
    logic [7:0]  r_prio;
    logic [15:0] r_rem;
    t_tok             r_tok;
    logic [IDX_W-1:0] r_cand_idx;

    t_tok n_tok;
    logic w_active;
    logic w_hit;
    logic w_last;

    always_comb begin
        w_active = (i_tok.scan_left != 5'd0);
        w_last   = (r_rem == 16'd1);
        w_hit    = w_active && (r_rem != 16'd0) && ({8'd0, r_arrival} <= i_tick)
                   && ({1'b0, r_prio} < i_tok.best_prio);
        n_tok = i_tok;
        if (w_active) begin
            n_tok.scan_left = i_tok.scan_left - 5'd1;
        end
        if (w_hit) begin
            n_tok.cand_valid   = 1'b1;
            n_tok.best_prio    = {1'b0, r_prio};
            n_tok.cand_arrival = r_arrival;
            n_tok.cand_burst   = r_burst;
            n_tok.cand_last    = w_last;
        end
        if (i_cur_idx == MY_IDX) begin
            n_tok.cur_arrival = r_arrival;
            n_tok.cur_burst   = r_burst;
            n_tok.cur_last    = w_last;
        end
    end

    // token moves on every cycle
    always_ff @(posedge i_clk) begin
        r_tok      <= n_tok;
        r_cand_idx <= w_hit ? MY_IDX : i_cand_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_load.en && (i_load_idx == MY_IDX)) begin
            r_arrival <= i_load.arrival;
            r_burst   <= i_load.burst;
            r_prio    <= i_load.prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 16'd0;
        end else if (i_load.en && (i_load_idx == MY_IDX)) begin
            r_rem <= i_load.burst;
        end else if (i_dec_en && (i_dec_idx == MY_IDX)) begin
            r_rem <= r_rem - 16'd1;
        end
    end

    assign o_tok      = r_tok;
    assign o_cand_idx = r_cand_idx;

endmodule

[rtl/core/preemptive_priority_scheduler_unit.sv]
// top level of the preemptive priority scheduler: control, cell row and completion maths
// tick request: accepted in idle, then runs the scan, execute and wait states, result registered in the output state
// load request: written at acceptance, result registered in the output state
// one request in flight; next accepted the cycle after the result is registered,
// so the pace of tick requests is set by the token walk along the cell row
// synchronous active-low reset clears control, time, counts, totals and remaining bursts
module preemptive_priority_scheduler_unit #(
    parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [3:0]  i_slot,
    input  logic [15:0] i_arrival,
    input  logic [15:0] i_burst,
    input  logic [7:0]  i_prio,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_idle,
    output logic [3:0]  o_running_slot,
    output logic        o_finished,
    output logic [23:0] o_turnaround,
    output logic [23:0] o_waiting,
    output logic [31:0] o_total_turnaround,
    output logic [31:0] o_total_waiting,
    output logic        o_all_done,
    // process_count register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import pps_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_PROCS - 1);

    // control state
    t_state r_state, n_state;
    logic [IDX_W-1:0] r_cnt;
    logic [4:0]  r_proc_count;
    logic        r_cur_valid;
    logic [IDX_W-1:0] r_cur_idx;
    logic [7:0]  r_cur_prio;
    logic [23:0] r_tick;
    logic [4:0]  r_fin_cnt;
    logic [31:0] r_sum_tat;
    logic [31:0] r_sum_wt;
    logic        r_o_valid;

    // per-request working registers
    logic        r_ran;
    logic        r_fin;
    logic [IDX_W-1:0] r_run_idx;
    logic [23:0] r_tat;
    logic [23:0] r_wt;
    logic [15:0] r_wburst;

    // result register
    logic        r_o_idle;
    logic [3:0]  r_o_slot;
    logic        r_o_fin;
    logic [23:0] r_o_tat;
    logic [23:0] r_o_wt;
    logic        r_o_all_done;

    // cell row
    t_tok             w_head;
    t_tok             w_tok [MAX_PROCS+1];
    logic [IDX_W-1:0] w_idx [MAX_PROCS+1];
    t_load            w_load;
    logic [IDX_W-1:0] w_load_idx;

    // control strobes
    logic w_accept;
    logic w_slot_ok;
    logic w_out_load;
    logic w_scan_end;
    logic w_dec_en;

    // winner of the scan
    t_tok             w_tail;
    logic             w_run;
    logic [IDX_W-1:0] w_win_idx;
    logic [15:0]      w_win_arr;
    logic [15:0]      w_win_burst;
    logic             w_win_last;
    logic [24:0]      w_done;
    logic [24:0]      w_tat_raw;
    logic [23:0]      w_tat;
    logic [4:0]       w_fin_cnt_nx;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_func == FUNC_TICK) ? ST_SCAN : ST_OUT;
                end
            end
            ST_SCAN: begin
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_WAIT;
            ST_WAIT: n_state = ST_OUT;
            ST_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- strobes
    always_comb begin
        o_stall    = 1'b1;
        w_accept   = 1'b0;
        w_scan_end = 1'b0;
        w_dec_en   = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall  = 1'b0;
                w_accept = i_valid;
            end
            ST_SCAN: w_scan_end = (r_cnt == LAST_CELL);
            ST_EXEC: w_dec_en   = w_run;
            ST_WAIT: w_dec_en   = 1'b0;
            ST_OUT:  w_out_load = !r_o_valid || !i_stall;
            default: o_stall    = 1'b1;
        endcase
    end

    // loads past the row are dropped
    assign w_slot_ok  = ({28'd0, i_slot} < 32'(MAX_PROCS));
    assign w_load_idx = IDX_W'(i_slot);

    always_comb begin
        w_load.en      = w_accept && (i_func == FUNC_LOAD) && w_slot_ok;
        w_load.arrival = i_arrival;
        w_load.burst   = i_burst;
        w_load.prio    = i_prio;
    end

    // ---------------------------------------------------------------- cell row
    // head token: the running slot's priority is the bar to beat
    always_comb begin
        w_head           = '0;
        w_head.best_prio = r_cur_valid ? {1'b0, r_cur_prio} : NO_PRIO;
        w_head.scan_left = r_proc_count;
    end

    assign w_tok[0] = w_head;
    assign w_idx[0] = '0;

    for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
        pps_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tok      (w_tok[k]),
            .i_cand_idx (w_idx[k]),
            .o_tok      (w_tok[k+1]),
            .o_cand_idx (w_idx[k+1]),
            .i_tick     (r_tick),
            .i_cur_idx  (r_cur_idx),
            .i_load     (w_load),
            .i_load_idx (w_load_idx),
            .i_dec_en   (w_dec_en),
            .i_dec_idx  (w_win_idx)
        );
    end

    // ---------------------------------------------------------------- winner pick
    // the tail token is held steady from the end of the scan until the decrement
    assign w_tail = w_tok[MAX_PROCS];

    always_comb begin
        w_run = w_tail.cand_valid || r_cur_valid;
        if (w_tail.cand_valid) begin
            w_win_idx   = w_idx[MAX_PROCS];
            w_win_arr   = w_tail.cand_arrival;
            w_win_burst = w_tail.cand_burst;
            w_win_last  = w_tail.cand_last;
        end else begin
            w_win_idx   = r_cur_idx;
            w_win_arr   = w_tail.cur_arrival;
            w_win_burst = w_tail.cur_burst;
            w_win_last  = w_tail.cur_last;
        end
        // turnaround = completion tick + 1 - arrival, clamped both ways
        w_done    = {1'b0, r_tick} + 25'd1;
        w_tat_raw = (w_done > {9'd0, w_win_arr}) ? (w_done - {9'd0, w_win_arr}) : 25'd0;
        w_tat     = (w_tat_raw > {1'b0, TICK_MAX}) ? TICK_MAX : w_tat_raw[23:0];
        w_fin_cnt_nx = (r_fin && (r_fin_cnt < FIN_MAX)) ? (r_fin_cnt + 5'd1) : r_fin_cnt;
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_proc_count <= PROC_COUNT_RST;
            r_cur_valid  <= 1'b0;
            r_cur_idx    <= '0;
            r_cur_prio   <= 8'd0;
            r_tick       <= 24'd0;
            r_fin_cnt    <= 5'd0;
            r_sum_tat    <= 32'd0;
            r_sum_wt     <= 32'd0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_proc_count <= i_cfg_data;
            end

            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end

            // reloading the running slot drops it
            if (w_load.en && r_cur_valid && (r_cur_idx == w_load_idx)) begin
                r_cur_valid <= 1'b0;
            end

            if (r_state == ST_EXEC) begin
                r_cur_valid <= w_run && !w_win_last;
                if (w_tail.cand_valid) begin
                    r_cur_idx  <= w_idx[MAX_PROCS];
                    r_cur_prio <= w_tail.best_prio[7:0];
                end
                if (r_tick != TICK_MAX) begin
                    r_tick <= r_tick + 24'd1;
                end
            end

            if (w_out_load) begin
                r_sum_tat <= sat_add32(r_sum_tat, {8'd0, r_tat});
                r_sum_wt  <= sat_add32(r_sum_wt, {8'd0, r_wt});
                r_fin_cnt <= w_fin_cnt_nx;
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ran <= 1'b0;
            r_fin <= 1'b0;
            r_tat <= 24'd0;
            r_wt  <= 24'd0;
        end
        if (r_state == ST_EXEC) begin
            r_ran     <= w_run;
            r_fin     <= w_run && w_win_last;
            r_run_idx <= w_win_idx;
            r_tat     <= (w_run && w_win_last) ? w_tat : 24'd0;
            r_wburst  <= w_win_burst;
        end
        if (r_state == ST_WAIT) begin
            // waiting time clamps at zero, only a completion carries one
            r_wt <= (r_fin && (r_tat > {8'd0, r_wburst})) ? (r_tat - {8'd0, r_wburst}) : 24'd0;
        end
        if (w_out_load) begin
            r_o_idle     <= !r_ran;
            r_o_slot     <= r_ran ? 4'(r_run_idx) : 4'd0;
            r_o_fin      <= r_fin;
            r_o_tat      <= r_tat;
            r_o_wt       <= r_wt;
            r_o_all_done <= (w_fin_cnt_nx >= r_proc_count);
        end
    end

    // register always takes a write; the user must keep writes between requests, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    assign o_valid            = r_o_valid;
    assign o_idle             = r_o_idle;
    assign o_running_slot     = r_o_slot;
    assign o_finished         = r_o_fin;
    assign o_turnaround       = r_o_tat;
    assign o_waiting          = r_o_wt;
    assign o_total_turnaround = r_sum_tat;
    assign o_total_waiting    = r_sum_wt;
    assign o_all_done         = r_o_all_done;

endmodule

[rtl/core/pps_checker.sv]
// port-level checker of the priority scheduler and its bind
`include "preemptive_priority_scheduler_unit_defines.svh"

module pps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_func,
    input logic [3:0]  i_slot,
    input logic [15:0] i_arrival,
    input logic [15:0] i_burst,
    input logic [7:0]  i_prio,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_idle,
    input logic [3:0]  o_running_slot,
    input logic        o_finished,
    input logic [23:0] o_turnaround,
    input logic [23:0] o_waiting,
    input logic [31:0] o_total_turnaround,
    input logic [31:0] o_total_waiting,
    input logic        o_all_done,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [4:0]  i_cfg_data
);

    // one request at a time: an accepted request closes the input
    `PPS_ASSERT_NEXT(a_accept_blocks, i_valid && !o_stall, o_stall)

    // a held result keeps its totals
    `PPS_ASSERT_NEXT(a_hold_result, o_valid && i_stall, o_valid && $stable(o_total_turnaround) && $stable(o_total_waiting))

    // an idle result carries no completion and no slot
    `PPS_ASSERT_NOW(a_idle_clean, o_valid && o_idle, !o_finished && (o_running_slot == 4'd0) && (o_turnaround == 24'd0) && (o_waiting == 24'd0))

    // waiting never exceeds turnaround
    `PPS_ASSERT_NOW(a_wait_bound, o_valid && o_finished, (o_waiting <= o_turnaround) && !o_idle)

endmodule

bind preemptive_priority_scheduler_unit pps_checker u_pps_checker (.*);
